// File: hdl/hex_grid_line_walker_macros.svh
// Assertion macros for the hex grid line walker checker.
`ifndef HEX_GRID_LINE_WALKER_MACROS_SVH
`define HEX_GRID_LINE_WALKER_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define HGW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hgw: assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define HGW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hgw: assertion failed");

`endif

// File: hdl/hgw_pkg.sv
// Package: types, constants and direction tables of the hex grid line walker.
package hgw_pkg;

	localparam int COORD_BITS_DEF = 5;
	localparam int MAX_STEPS      = 64;
	localparam int STEP_CNT_W     = $clog2(MAX_STEPS);
	// sized for the default coordinate width: start plus up to MAX_STEPS unit moves
	localparam int WALK_W         = 8;
	localparam int ERR_W          = 12;

	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [WALK_W-1:0] walk_coord_t;

	// major step index into the direction tables
	localparam logic [1:0] IDX_NEG  = 2'd0;
	localparam logic [1:0] IDX_ZERO = 2'd1;
	localparam logic [1:0] IDX_POS  = 2'd2;

	// [column parity][side][major index] -> row delta
	localparam logic signed [1:0] STEP_COL_TAB [2][2][3] = '{
		'{ '{-2'sd1, -2'sd1,  2'sd0}, '{-2'sd1,  2'sd1,  2'sd0} },
		'{ '{ 2'sd0, -2'sd1,  2'sd1}, '{ 2'sd0,  2'sd1,  2'sd1} }
	};

	// [column parity][side][major index] -> column delta
	localparam logic signed [1:0] STEP_ROW_TAB [2][2][3] = '{
		'{ '{-2'sd1,  2'sd0, -2'sd1}, '{ 2'sd1,  2'sd0,  2'sd1} },
		'{ '{-2'sd1,  2'sd0, -2'sd1}, '{ 2'sd1,  2'sd0,  2'sd1} }
	};

	typedef struct packed {
		logic maj_neg;
		logic min_neg;
		err_t init_err;
		err_t th_hi;
		err_t th_lo;
		err_t add_a;
		err_t add_b;
		err_t add_c;
	} walk_params_t;

	typedef struct packed {
		logic ld_delta;
		logic ld_const;
	} setup_ctrl_t;

	typedef struct packed {
		logic load;
		logic adv;
	} step_ctrl_t;

	function automatic walk_coord_t step_dy(logic par, logic side, logic [1:0] idx);
		walk_coord_t d;
		d = WALK_W'(STEP_COL_TAB[par][side][idx]);
		return d;
	endfunction

	function automatic walk_coord_t step_dx(logic par, logic side, logic [1:0] idx);
		walk_coord_t d;
		d = WALK_W'(STEP_ROW_TAB[par][side][idx]);
		return d;
	endfunction

endpackage

// File: hdl/hgw_ifs.sv
// Valid/ready channel interfaces: walk request in, visited cell out.
interface hgw_in_if import hgw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface hgw_out_if import hgw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] cell_x;
	logic [COORD_BITS-1:0] cell_y;
	logic                  last;

	modport source (output valid, cell_x, cell_y, last, input ready);
	modport sink   (input valid, cell_x, cell_y, last, output ready);
endinterface

// File: hdl/hgw_setup.sv
// Setup: spans and signs are registered first, then error thresholds and increments.
module hgw_setup import hgw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  setup_ctrl_t           ctrl,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output walk_params_t          prm
);

	err_t d_row, d_row2, d_col, dmaj, dmin, init_err;
	logic maj_neg, min_neg;
	err_t m3, j3;

	logic maj_neg_q, min_neg_q;
	err_t dmaj_q, dmin_q, init_q;
	err_t th_hi_q, th_lo_q, add_a_q, add_b_q, add_c_q;

	always_comb begin
		d_row  = err_t'(ERR_W'(end_y)) - err_t'(ERR_W'(start_y));
		d_col  = err_t'(ERR_W'(end_x)) - err_t'(ERR_W'(start_x));
		d_row2 = (d_row <<< 1) + err_t'(ERR_W'(end_x[0])) - err_t'(ERR_W'(start_x[0]));
		// odd start column: a zero row difference steps the negative way
		maj_neg  = start_x[0] ? (d_row[ERR_W-1] || d_row == '0) : d_row[ERR_W-1];
		min_neg  = d_col[ERR_W-1];
		dmaj     = d_row2[ERR_W-1] ? -d_row2 : d_row2;
		dmin     = d_col[ERR_W-1] ? -d_col : d_col;
		init_err = -(dmaj <<< 1);
		m3       = dmin_q + (dmin_q <<< 1);
		j3       = dmaj_q + (dmaj_q <<< 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maj_neg_q <= 1'b0;
			min_neg_q <= 1'b0;
			dmaj_q    <= '0;
			dmin_q    <= '0;
			init_q    <= '0;
		end else if (ctrl.ld_delta) begin
			maj_neg_q <= maj_neg;
			min_neg_q <= min_neg;
			dmaj_q    <= dmaj;
			dmin_q    <= dmin;
			init_q    <= init_err;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_const) begin
			th_hi_q <= -dmaj_q - m3;
			th_lo_q <= -(j3 + m3);
			add_a_q <= m3 - j3;
			add_b_q <= m3 + j3;
			add_c_q <= m3 <<< 1;
		end
	end

	always_comb begin
		prm.maj_neg  = maj_neg_q;
		prm.min_neg  = min_neg_q;
		prm.init_err = init_q;
		prm.th_hi    = th_hi_q;
		prm.th_lo    = th_lo_q;
		prm.add_a    = add_a_q;
		prm.add_b    = add_b_q;
		prm.add_c    = add_c_q;
	end

endmodule

// File: hdl/hgw_step.sv
// Step unit: error update, direction lookup and one hex move per advance.
module hgw_step import hgw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  step_ctrl_t            ctrl,
	input  walk_params_t          prm,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic [COORD_BITS-1:0] cell_x,
	output logic [COORD_BITS-1:0] cell_y,
	output logic                  done
);

	err_t        err_q, err_n;
	walk_coord_t wx_q, wy_q, wx_n, wy_n;
	logic [1:0]  idx;
	logic        side;

	always_comb begin
		if (!err_q[ERR_W-1]) begin
			err_n = err_q + prm.th_lo;
			idx   = prm.maj_neg ? IDX_POS : IDX_NEG;
			side  = !prm.min_neg;
		end else if (err_q > prm.th_hi) begin
			err_n = err_q + prm.add_a;
			idx   = prm.maj_neg ? IDX_NEG : IDX_POS;
			side  = !prm.min_neg;
		end else if (err_q < prm.th_lo) begin
			err_n = err_q + prm.add_b;
			idx   = prm.maj_neg ? IDX_NEG : IDX_POS;
			side  = prm.min_neg;
		end else begin
			// row-only move along the major axis
			err_n = err_q + prm.add_c;
			idx   = IDX_ZERO;
			side  = !prm.maj_neg;
		end
		wx_n   = wx_q + step_dx(wx_q[0], side, idx);
		wy_n   = wy_q + step_dy(wx_q[0], side, idx);
		done   = (wx_n == WALK_W'(end_x)) && (wy_n == WALK_W'(end_y));
		cell_x = wx_n[COORD_BITS-1:0];
		cell_y = wy_n[COORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= '0;
			wx_q  <= '0;
			wy_q  <= '0;
		end else if (ctrl.load) begin
			err_q <= prm.init_err;
			wx_q  <= WALK_W'(start_x);
			wy_q  <= WALK_W'(start_y);
		end else if (ctrl.adv) begin
			err_q <= err_n;
			wx_q  <= wx_n;
			wy_q  <= wy_n;
		end
	end

endmodule

// File: hdl/hex_grid_line_walker.sv
// Hex grid line walker top level: sequencer, request capture and cell output register.
//
// walk_req carries a start and an end cell of an offset hex grid; walk_cell
// returns every hex visited after the start, one transaction per cell, with
// last set on the end cell. A request whose start equals its end yields no
// cells and the block stays ready.
// After a request is taken, the DELTA and CONST setup states compute spans and error
// thresholds; the first cell is then registered, and one cell follows per cycle from
// the step unit as long as walk_cell.ready does not hold back a pending cell.
// A walk of n cells (n at most 64) keeps walk_req.ready low through the setup states
// and the walk, stalls included; ready returns at the edge that registers the last
// cell, so the next request overlaps the final handoff.
// A walk that has not reached its end after 64 cells stops, with no cell
// flagged last.
// When walk_cell.ready is low, the pending cell holds and the step unit
// freezes until it is taken.
// arst_n clears the sequencer to idle and drops walk_cell.valid.
module hex_grid_line_walker import hgw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hgw_in_if.sink    walk_req,
	hgw_out_if.source walk_cell
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DELTA = 2'd1;
	localparam logic [1:0] ST_CONST = 2'd2;
	localparam logic [1:0] ST_WALK  = 2'd3;

	logic [1:0]            state_q;
	logic [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  out_valid_q, last_q;
	logic [COORD_BITS-1:0] cell_x_q, cell_y_q;

	logic                  req_fire, same_cell, adv, stop;
	logic [COORD_BITS-1:0] nxt_x, nxt_y;
	logic                  nxt_done;
	setup_ctrl_t           setup_ctrl;
	step_ctrl_t            step_ctrl;
	walk_params_t          prm;

	assign walk_req.ready = (state_q == ST_IDLE);
	assign req_fire       = walk_req.valid && walk_req.ready;
	assign same_cell      = (walk_req.start_x == walk_req.end_x) &&
	                        (walk_req.start_y == walk_req.end_y);
	assign adv            = (state_q == ST_WALK) && (!out_valid_q || walk_cell.ready);
	assign stop           = nxt_done || (cnt_q == STEP_CNT_W'(MAX_STEPS - 1));

	assign setup_ctrl.ld_delta = (state_q == ST_DELTA);
	assign setup_ctrl.ld_const = (state_q == ST_CONST);
	assign step_ctrl.load      = (state_q == ST_CONST);
	assign step_ctrl.adv       = adv;

	hgw_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (setup_ctrl),
		.start_x (sx_q),
		.start_y (sy_q),
		.end_x   (ex_q),
		.end_y   (ey_q),
		.prm     (prm)
	);

	hgw_step #(.COORD_BITS(COORD_BITS)) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (step_ctrl),
		.prm     (prm),
		.start_x (sx_q),
		.start_y (sy_q),
		.end_x   (ex_q),
		.end_y   (ey_q),
		.cell_x  (nxt_x),
		.cell_y  (nxt_y),
		.done    (nxt_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire && !same_cell) begin
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: state_q <= ST_CONST;
				ST_CONST: begin
					state_q <= ST_WALK;
					cnt_q   <= '0;
				end
				ST_WALK: begin
					if (adv) begin
						cnt_q <= cnt_q + 1'b1;
						if (stop) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			sx_q <= walk_req.start_x;
			sy_q <= walk_req.start_y;
			ex_q <= walk_req.end_x;
			ey_q <= walk_req.end_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (walk_cell.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_x_q <= nxt_x;
			cell_y_q <= nxt_y;
			last_q   <= nxt_done;
		end
	end

	assign walk_cell.valid  = out_valid_q;
	assign walk_cell.cell_x = cell_x_q;
	assign walk_cell.cell_y = cell_y_q;
	assign walk_cell.last   = last_q;

endmodule

// File: hdl/hgw_chk.sv
// Port-level checker for the hex grid line walker, bound to the top level.
`include "hex_grid_line_walker_macros.svh"

module hgw_chk import hgw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [COORD_BITS-1:0] start_x,
	input logic [COORD_BITS-1:0] start_y,
	input logic [COORD_BITS-1:0] end_x,
	input logic [COORD_BITS-1:0] end_y,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] cell_x,
	input logic [COORD_BITS-1:0] cell_y,
	input logic                  last
);

	logic                  req_fire;
	logic                  req_null;
	logic [2*COORD_BITS:0] cell_bits;

	assign req_fire  = in_valid && in_ready;
	assign req_null  = (start_x == end_x) && (start_y == end_y);
	assign cell_bits = {cell_x, cell_y, last};

	// a real walk makes the block busy right away
	`HGW_ASSERT_NEXT(a_busy_after_walk, clk, arst_n, req_fire && !req_null, !in_ready)

	// a request with start equal to end leaves the block idle
	`HGW_ASSERT_NEXT(a_idle_after_null, clk, arst_n, req_fire && req_null, in_ready)

	// the end cell finishes the walk
	`HGW_ASSERT_NOW(a_idle_at_last, clk, arst_n, $rose(out_valid && last), in_ready)

	`HGW_ASSERT_NEXT(a_cell_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(cell_bits))

endmodule

bind hex_grid_line_walker hgw_chk #(.COORD_BITS(COORD_BITS)) u_hgw_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (walk_req.valid),
	.in_ready  (walk_req.ready),
	.start_x   (walk_req.start_x),
	.start_y   (walk_req.start_y),
	.end_x     (walk_req.end_x),
	.end_y     (walk_req.end_y),
	.out_valid (walk_cell.valid),
	.out_ready (walk_cell.ready),
	.cell_x    (walk_cell.cell_x),
	.cell_y    (walk_cell.cell_y),
	.last      (walk_cell.last)
);

// File: test/hex_grid_line_walker_tb.sv
// Testbench for hex_grid_line_walker: random and directed walks checked against a local walk model.
module hex_grid_line_walker_tb import hgw_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB        = COORD_BITS_DEF;
	localparam int CELL_CAP  = 64;
	localparam int RAND_WALKS = 420;
	localparam int CALM_TAIL = 50;
	localparam int LINGER    = 100;

	// [column parity][side][major index] -> row move / column move
	localparam int DY_TAB [2][2][3] = '{
		'{ '{-1, -1, 0}, '{-1, 1, 0} },
		'{ '{ 0, -1, 1}, '{ 0, 1, 1} }
	};
	localparam int DX_TAB [2][2][3] = '{
		'{ '{-1, 0, -1}, '{1, 0, 1} },
		'{ '{-1, 0, -1}, '{1, 0, 1} }
	};

	typedef struct {
		logic [CB-1:0] sx;
		logic [CB-1:0] sy;
		logic [CB-1:0] ex;
		logic [CB-1:0] ey;
		bit            hold;  // wait until every cell in flight has come back
		bit            calm;  // end of run: no idling on either side
	} walk_req_t;

	typedef struct {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic          last;
	} cell_t;

	logic clk;
	logic arst_n;

	hgw_in_if  #(.COORD_BITS(CB)) req_ch ();
	hgw_out_if #(.COORD_BITS(CB)) cell_ch ();

	hex_grid_line_walker #(.COORD_BITS(CB)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.walk_req  (req_ch),
		.walk_cell (cell_ch)
	);

	walk_req_t walks_pending[$];
	cell_t     cells_due[$];
	int        mismatches;
	int        req_gap;
	int        sink_stall;
	bit        req_taken;
	bit        quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void hex_step(inout int cx, inout int cy, input int maj, input int side_sgn);
		int par;
		int side;
		par  = cx & 1;
		side = (side_sgn < 0) ? 0 : 1;
		cy += DY_TAB[par][side][maj + 1];
		cx += DX_TAB[par][side][maj + 1];
	endfunction

	// Walks the line of sight and queues every cell after the start.
	function automatic void trace_line(input logic [CB-1:0] sx_i, sy_i, ex_i, ey_i);
		int    sx, sy, ex, ey, cx, cy, err, d_row, span_maj, span_min, dir_maj, dir_min, n;
		bit    arrived;
		cell_t c;
		sx = sx_i;
		sy = sy_i;
		ex = ex_i;
		ey = ey_i;
		if (sx == ex && sy == ey)
			return;
		d_row = ey - sy;
		span_maj = 2 * d_row + (ex & 1) - (sx & 1);
		if (sx & 1)
			dir_maj = (d_row <= 0) ? -1 : 1;
		else
			dir_maj = (d_row < 0) ? -1 : 1;
		dir_min = (ex - sx < 0) ? -1 : 1;
		if (span_maj < 0)
			span_maj = -span_maj;
		span_min = (ex - sx < 0) ? sx - ex : ex - sx;
		cx = sx;
		cy = sy;
		err = -2 * span_maj;
		arrived = 1'b0;
		n = 0;
		while (!arrived && n < CELL_CAP) begin
			if (err >= 0) begin
				err -= 3 * (span_min + span_maj);
				hex_step(cx, cy, -dir_maj, dir_min);
			end else begin
				err += 3 * span_min;
				if (err > -span_maj) begin
					err -= 3 * span_maj;
					hex_step(cx, cy, dir_maj, dir_min);
				end else if (err < -3 * span_maj) begin
					err += 3 * span_maj;
					hex_step(cx, cy, dir_maj, -dir_min);
				end else begin
					err += 3 * span_min;
					hex_step(cx, cy, 0, dir_maj);
				end
			end
			arrived = (cx == ex && cy == ey);
			// coordinates off the grid wrap modulo the grid size
			c.x = cx[CB-1:0];
			c.y = cy[CB-1:0];
			c.last = arrived;
			cells_due.push_back(c);
			n++;
		end
	endfunction

	function automatic void note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, what);
	endfunction

	// request driver
	always @(negedge clk) begin
		walk_req_t nxt;
		logic      v;
		if (arst_n) begin
			v = req_ch.valid;
			if (req_taken || !req_ch.valid) begin
				v = 1'b0;
				if (req_gap > 0) begin
					req_gap <= req_gap - 1;
				end else if (walks_pending.size() > 0) begin
					nxt = walks_pending[0];
					if (nxt.calm)
						quiet <= 1'b1;
					if (nxt.hold && cells_due.size() != 0) begin
						// drain: hold off until the walker has returned everything
					end else if (!nxt.calm && $urandom_range(0, 7) == 0) begin
						req_gap <= $urandom_range(0, 14);
					end else begin
						void'(walks_pending.pop_front());
						req_ch.start_x <= nxt.sx;
						req_ch.start_y <= nxt.sy;
						req_ch.end_x   <= nxt.ex;
						req_ch.end_y   <= nxt.ey;
						v = 1'b1;
					end
				end
			end
			req_ch.valid <= v;
		end
	end

	// cell sink back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (quiet) begin
				cell_ch.ready <= 1'b1;
			end else if (sink_stall > 0) begin
				cell_ch.ready <= 1'b0;
				sink_stall <= sink_stall - 1;
			end else if ($urandom_range(0, 9) == 0) begin
				cell_ch.ready <= 1'b0;
				sink_stall <= $urandom_range(0, 14);
			end else begin
				cell_ch.ready <= 1'b1;
			end
		end
	end

	// monitor: check returned cells, then predict for a newly accepted request
	always @(posedge clk or negedge arst_n) begin
		cell_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (cell_ch.valid && cell_ch.ready) begin
				if (cells_due.size() == 0) begin
					note_mismatch($sformatf("unexpected cell x=%0d y=%0d last=%0b",
						cell_ch.cell_x, cell_ch.cell_y, cell_ch.last));
				end else begin
					want = cells_due.pop_front();
					if (cell_ch.cell_x !== want.x || cell_ch.cell_y !== want.y ||
					    cell_ch.last !== want.last)
						note_mismatch($sformatf(
							"cell mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
							want.x, want.y, want.last,
							cell_ch.cell_x, cell_ch.cell_y, cell_ch.last));
				end
			end
			if (req_ch.valid && req_ch.ready)
				trace_line(req_ch.start_x, req_ch.start_y, req_ch.end_x, req_ch.end_y);
		end
	end

	initial begin
		walk_req_t w;
		int        mode;
		int        directed [20][4] = '{
			'{ 0,  0,  0,  0}, '{31, 31, 31, 31}, '{ 0,  0, 31, 31}, '{31, 31,  0,  0},
			'{ 0, 31, 31,  0}, '{31,  0,  0, 31}, '{ 0,  0,  1,  0}, '{ 1,  0,  0,  0},
			'{ 1,  5,  1,  0}, '{ 2,  0,  2, 31}, '{ 0, 16, 31, 16}, '{31, 16,  0, 16},
			'{10, 10, 11, 10}, '{11, 10, 10, 10}, '{11, 10, 11, 11}, '{10, 10, 10,  9},
			'{ 0,  0,  0, 31}, '{ 0,  0, 31,  0}, '{ 5, 20, 12,  3}, '{21,  2,  7, 30}
		};
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.start_x = '0;
		req_ch.start_y = '0;
		req_ch.end_x = '0;
		req_ch.end_y = '0;
		cell_ch.ready = 1'b0;
		req_taken = 1'b0;
		quiet = 1'b0;
		mismatches = 0;
		req_gap = 0;
		sink_stall = 0;

		foreach (directed[i]) begin
			w.sx = CB'(directed[i][0]);
			w.sy = CB'(directed[i][1]);
			w.ex = CB'(directed[i][2]);
			w.ey = CB'(directed[i][3]);
			w.hold = 1'b0;
			w.calm = 1'b0;
			walks_pending.push_back(w);
		end
		for (int i = 0; i < RAND_WALKS; i++) begin
			mode = $urandom_range(0, 15);
			w.sx = CB'($urandom_range(0, (1 << CB) - 1));
			w.sy = CB'($urandom_range(0, (1 << CB) - 1));
			if (mode == 0) begin
				w.ex = w.sx;
				w.ey = w.sy;
			end else if (mode <= 4) begin
				// short hop, wrapping at the grid edge
				w.ex = CB'(int'(w.sx) + $urandom_range(0, 6) - 3);
				w.ey = CB'(int'(w.sy) + $urandom_range(0, 6) - 3);
			end else begin
				w.ex = CB'($urandom_range(0, (1 << CB) - 1));
				w.ey = CB'($urandom_range(0, (1 << CB) - 1));
			end
			w.hold = (i == 0 || i == RAND_WALKS / 2);
			w.calm = (i >= RAND_WALKS - CALM_TAIL);
			walks_pending.push_back(w);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (walks_pending.size() != 0 || req_ch.valid)
			@(negedge clk);
		while (cells_due.size() != 0)
			@(negedge clk);
		repeat (LINGER) @(negedge clk);
		if (mismatches == 0 && cells_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
